/* rtl/opi_pkg.sv */
// ----------------------------------------------------------------------------
// opi_pkg
// Shared types, constants and tables for the odometry pose integrator.
// ----------------------------------------------------------------------------
package opi_pkg;

	// Pose storage widths
	localparam int POSITION_BITS = 32;
	localparam int ANGLE_BITS    = 16;

	// Status codes of an input item
	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_MISSING = 2'd1;

	// Rotation unit
	localparam int CORDIC_ITERS = 24;
	localparam int CRD_W        = 33;
	localparam int ITER_W       = 5;
	localparam logic signed [CRD_W-1:0] CRD_QUARTER = 33'sd1073741824;
	localparam logic signed [CRD_W-1:0] CRD_HALF    = 33'sd2147483648;

	// Serial multiplier
	localparam int MUL_A_W  = 33;
	localparam int MUL_B_W  = 31;
	localparam int MUL_HI_W = MUL_A_W + 1;
	localparam int SHORT_STEPS = 16;
	localparam int LONG_STEPS  = 31;
	localparam logic [MUL_B_W-1:0] CORDIC_INV_GAIN = 31'd39797;
	localparam logic [MUL_B_W-1:0] INV_PI_Q32      = 31'd1367130551;

	// Displacement: (hi + 2^9) >>> 10 after a 16 step product
	localparam int DX_SH = 10;
	localparam int DX_W  = MUL_HI_W - DX_SH;
	// Heading step: (hi + 2^(29-A)) >>> (30-A) after a 31 step product
	localparam int HD_SH = 30 - ANGLE_BITS;

	typedef enum logic [2:0] {
		S_IDLE, S_ROT, S_GLOAD, S_GAIN, S_SLOAD, S_SCALE, S_UPD, S_MISS
	} opi_state_t;

	typedef enum logic [2:0] {
		H_IDLE, H_MUL1, H_LOAD2, H_MUL2, H_DONE
	} opi_hstate_t;

	typedef struct packed {
		logic load;
		logic step;
	} opi_mul_ctl_t;

	typedef struct packed {
		logic              load;
		logic              step;
		logic [ITER_W-1:0] iter;
	} opi_crd_ctl_t;

	// Arctangent table, 2^32 per full turn
	function automatic logic [31:0] cordic_atan(input logic [ITER_W-1:0] idx);
		logic [31:0] v;
		unique case (idx)
			5'd0:  v = 32'd536870912;
			5'd1:  v = 32'd316933406;
			5'd2:  v = 32'd167458907;
			5'd3:  v = 32'd85004756;
			5'd4:  v = 32'd42667331;
			5'd5:  v = 32'd21354465;
			5'd6:  v = 32'd10679838;
			5'd7:  v = 32'd5340245;
			5'd8:  v = 32'd2670163;
			5'd9:  v = 32'd1335087;
			5'd10: v = 32'd667544;
			5'd11: v = 32'd333772;
			5'd12: v = 32'd166886;
			5'd13: v = 32'd83443;
			5'd14: v = 32'd41722;
			5'd15: v = 32'd20861;
			5'd16: v = 32'd10430;
			5'd17: v = 32'd5215;
			5'd18: v = 32'd2608;
			5'd19: v = 32'd1304;
			5'd20: v = 32'd652;
			5'd21: v = 32'd326;
			5'd22: v = 32'd163;
			5'd23: v = 32'd81;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

/* rtl/opi_mul.sv */
// ----------------------------------------------------------------------------
// opi_mul
// Bit-serial signed-by-unsigned multiplier, one bit of b per cycle on step.
// After N steps, hi holds floor(a*b / 2^N) and the top N bits of lo hold the
// low N product bits.
// ----------------------------------------------------------------------------
module opi_mul (
	input  logic                                clk,
	input  logic                                arst_n,
	input  opi_pkg::opi_mul_ctl_t               ctl,
	input  logic signed [opi_pkg::MUL_A_W-1:0]  a,
	input  logic        [opi_pkg::MUL_B_W-1:0]  b,
	output logic signed [opi_pkg::MUL_HI_W-1:0] hi,
	output logic        [opi_pkg::MUL_B_W-1:0]  lo
);
	import opi_pkg::*;

	logic signed [MUL_A_W-1:0]  a_q;
	logic signed [MUL_HI_W-1:0] hi_q;
	logic        [MUL_B_W-1:0]  b_q;
	logic signed [MUL_HI_W:0]   sum;

	// partial product added on the current multiplier bit
	always_comb begin
		sum = {hi_q[MUL_HI_W-1], hi_q};
		if (b_q[0]) begin
			sum = sum + {{2{a_q[MUL_A_W-1]}}, a_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hi_q <= '0;
		end else if (ctl.load) begin
			hi_q <= '0;
		end else if (ctl.step) begin
			hi_q <= sum[MUL_HI_W:1];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			a_q <= a;
			b_q <= b;
		end else if (ctl.step) begin
			b_q <= {sum[0], b_q[MUL_B_W-1:1]};
		end
	end

	assign hi = hi_q;
	assign lo = b_q;

endmodule

/* rtl/opi_cordic.sv */
// ----------------------------------------------------------------------------
// opi_cordic
// Iterative CORDIC rotator, one micro-rotation per step. The load folds the
// angle into +-pi/2 and scales the vector by 2^14.
// ----------------------------------------------------------------------------
module opi_cordic (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  opi_pkg::opi_crd_ctl_t                ctl,
	input  logic signed [15:0]                   vel_x,
	input  logic signed [15:0]                   vel_y,
	input  logic        [opi_pkg::ANGLE_BITS-1:0] angle,
	output logic signed [opi_pkg::CRD_W-1:0]     x_out,
	output logic signed [opi_pkg::CRD_W-1:0]     y_out
);
	import opi_pkg::*;

	logic signed [CRD_W-1:0] x_q, y_q, z_q;
	logic signed [CRD_W-1:0] x0, y0, z0, xf, yf, zf;
	logic signed [CRD_W-1:0] dx, dy, at;
	logic        [31:0]      a32;
	logic        [ANGLE_BITS+31:0] a_wide;

	// load path: widen angle to 32 bits, fold beyond +-pi/2
	always_comb begin
		a_wide = {angle, 32'b0};
		a32    = a_wide[ANGLE_BITS+31 -: 32];
		z0     = {a32[31], a32};
		x0     = {{3{vel_x[15]}}, vel_x, 14'b0};
		y0     = {{3{vel_y[15]}}, vel_y, 14'b0};
		xf     = x0;
		yf     = y0;
		zf     = z0;
		if (z0 > CRD_QUARTER) begin
			xf = -x0;
			yf = -y0;
			zf = z0 - CRD_HALF;
		end else if (z0 < -CRD_QUARTER) begin
			xf = -x0;
			yf = -y0;
			zf = z0 + CRD_HALF;
		end
	end

	always_comb begin
		dx = y_q >>> ctl.iter;
		dy = x_q >>> ctl.iter;
		at = {1'b0, cordic_atan(ctl.iter)};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			y_q <= '0;
			z_q <= '0;
		end else if (ctl.load) begin
			x_q <= xf;
			y_q <= yf;
			z_q <= zf;
		end else if (ctl.step) begin
			if (!z_q[CRD_W-1]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
	end

	assign x_out = x_q;
	assign y_out = y_q;

endmodule

/* rtl/odometry_pose_integrator.sv */
// ----------------------------------------------------------------------------
// odometry_pose_integrator
// Planar dead-reckoning: integrates body velocities into an x/y/heading pose.
// ----------------------------------------------------------------------------
// A valid sample runs through these steps before the block takes the next
// item: 24 CORDIC iterations rotate the velocity by the stored heading,
// then two bit-serial multipliers (one per axis) run 16 steps to remove the
// CORDIC gain and 16 steps to scale by the period, each after a load state,
// and then an update state. The heading step (turn_rate * period * 1/pi, two
// products in a third serial multiplier) runs alongside and never adds time.
// A missing sample emits a result, a malformed one is only counted. The
// result sits in an output register, so a new item is accepted while the
// last one is still waiting; the update stalls only if that register is full.
module odometry_pose_integrator (
	input  logic        clk,
	input  logic        arst_n,
	// input item
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  status,
	input  logic signed [15:0] vel_x,
	input  logic signed [15:0] vel_y,
	input  logic signed [15:0] turn_rate,
	input  logic [15:0] period,
	// result item
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [15:0] heading,
	output logic signed [15:0] out_vel_x,
	output logic signed [15:0] out_vel_y,
	output logic signed [15:0] out_turn_rate,
	output logic [15:0] missed_reads,
	output logic [15:0] bad_samples
);
	import opi_pkg::*;

	// sequencers
	opi_state_t  state_q, state_d;
	opi_hstate_t hst_q, hst_d;
	logic [ITER_W-1:0] cnt_q, cnt_d;
	logic [ITER_W-1:0] hcnt_q, hcnt_d;

	// pose and counters
	logic signed [POSITION_BITS-1:0] px_q, py_q, px_new, py_new;
	logic [ANGLE_BITS-1:0] hd_q, hd_new;
	logic [15:0] missed_q, bad_q, missed_inc, bad_inc;

	// captured sample
	logic signed [15:0] vx_q, vy_q, vt_q;
	logic [15:0] per_q;

	// output register
	logic out_valid_q;
	logic signed [31:0] pos_x_q, pos_y_q;
	logic signed [15:0] heading_q, ovx_q, ovy_q, ovt_q;
	logic [15:0] missed_o_q, bad_o_q;

	// control
	logic out_free, cap_en, bad_hit, miss_emit, upd, h_start;
	opi_crd_ctl_t crd_ctl;
	opi_mul_ctl_t mxy_ctl, mh_ctl;

	// datapath
	logic signed [CRD_W-1:0]    cx, cy;
	logic signed [MUL_A_W-1:0]  mx_a, my_a, mh_a;
	logic        [MUL_B_W-1:0]  mxy_b, mh_b;
	logic signed [MUL_HI_W-1:0] mx_hi, my_hi, mh_hi;
	logic        [MUL_B_W-1:0]  mh_lo;
	logic signed [31:0]         vtp;
	logic signed [MUL_HI_W-1:0] xr, yr, hr;
	logic signed [DX_W-1:0]     dx, dy;
	logic signed [POSITION_BITS:0] sx, sy;
	logic signed [POSITION_BITS+31:0] px_ext, py_ext;
	logic [ANGLE_BITS+15:0] hd_ext;

	assign out_free = !out_valid_q || out_ready;

	// ---- units ----
	opi_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (crd_ctl),
		.vel_x  (vel_x),
		.vel_y  (vel_y),
		.angle  (hd_q),
		.x_out  (cx),
		.y_out  (cy)
	);

	opi_mul u_mul_x (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mxy_ctl),
		.a      (mx_a),
		.b      (mxy_b),
		.hi     (mx_hi),
		.lo     ()
	);

	opi_mul u_mul_y (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mxy_ctl),
		.a      (my_a),
		.b      (mxy_b),
		.hi     (my_hi),
		.lo     ()
	);

	opi_mul u_mul_h (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mh_ctl),
		.a      (mh_a),
		.b      (mh_b),
		.hi     (mh_hi),
		.lo     (mh_lo)
	);

	// gain removal takes the rotated vector, scaling takes the gain-removed result
	always_comb begin
		if (state_q == S_GLOAD) begin
			mx_a  = cx;
			my_a  = cy;
			mxy_b = CORDIC_INV_GAIN;
		end else begin
			mx_a  = mx_hi[MUL_A_W-1:0];
			my_a  = my_hi[MUL_A_W-1:0];
			mxy_b = {{(MUL_B_W-16){1'b0}}, per_q};
		end
	end

	// heading chain: turn_rate*period, then times 1/pi
	assign vtp = {mh_hi[15:0], mh_lo[MUL_B_W-1 -: SHORT_STEPS]};
	always_comb begin
		if (hst_q == H_IDLE) begin
			mh_a = {{(MUL_A_W-16){turn_rate[15]}}, turn_rate};
			mh_b = {{(MUL_B_W-16){1'b0}}, period};
		end else begin
			mh_a = {vtp[31], vtp};
			mh_b = INV_PI_Q32;
		end
	end

	// ---- rounding, saturation, pose update ----
	always_comb begin
		xr = mx_hi + (MUL_HI_W'(1) <<< (DX_SH - 1));
		yr = my_hi + (MUL_HI_W'(1) <<< (DX_SH - 1));
		dx = xr[MUL_HI_W-1:DX_SH];
		dy = yr[MUL_HI_W-1:DX_SH];
		sx = {px_q[POSITION_BITS-1], px_q} + {{(POSITION_BITS+1-DX_W){dx[DX_W-1]}}, dx};
		sy = {py_q[POSITION_BITS-1], py_q} + {{(POSITION_BITS+1-DX_W){dy[DX_W-1]}}, dy};
		// overflow shows as the two top bits differing
		px_new = sx[POSITION_BITS-1:0];
		if (sx[POSITION_BITS] != sx[POSITION_BITS-1]) begin
			px_new = {sx[POSITION_BITS], {(POSITION_BITS-1){!sx[POSITION_BITS]}}};
		end
		py_new = sy[POSITION_BITS-1:0];
		if (sy[POSITION_BITS] != sy[POSITION_BITS-1]) begin
			py_new = {sy[POSITION_BITS], {(POSITION_BITS-1){!sy[POSITION_BITS]}}};
		end
		hr     = mh_hi + (MUL_HI_W'(1) <<< (HD_SH - 1));
		hd_new = hd_q + hr[HD_SH +: ANGLE_BITS];
	end

	assign missed_inc = (missed_q == 16'hFFFF) ? missed_q : missed_q + 16'd1;
	assign bad_inc    = (bad_q == 16'hFFFF) ? bad_q : bad_q + 16'd1;

	// ---- main sequencer ----
	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		in_ready  = 1'b0;
		cap_en    = 1'b0;
		bad_hit   = 1'b0;
		miss_emit = 1'b0;
		upd       = 1'b0;
		h_start   = 1'b0;
		crd_ctl   = '0;
		mxy_ctl   = '0;
		crd_ctl.iter = cnt_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					priority if (status == STAT_OK) begin
						cap_en       = 1'b1;
						crd_ctl.load = 1'b1;
						h_start      = 1'b1;
						cnt_d        = '0;
						state_d      = S_ROT;
					end else if (status == STAT_MISSING) begin
						state_d = S_MISS;
					end else begin
						bad_hit = 1'b1;
					end
				end
			end
			S_ROT: begin
				crd_ctl.step = 1'b1;
				if (cnt_q == ITER_W'(CORDIC_ITERS - 1)) begin
					state_d = S_GLOAD;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_GLOAD: begin
				mxy_ctl.load = 1'b1;
				cnt_d        = '0;
				state_d      = S_GAIN;
			end
			S_GAIN: begin
				mxy_ctl.step = 1'b1;
				if (cnt_q == ITER_W'(SHORT_STEPS - 1)) begin
					state_d = S_SLOAD;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_SLOAD: begin
				mxy_ctl.load = 1'b1;
				cnt_d        = '0;
				state_d      = S_SCALE;
			end
			S_SCALE: begin
				mxy_ctl.step = 1'b1;
				if (cnt_q == ITER_W'(SHORT_STEPS - 1)) begin
					state_d = S_UPD;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_UPD: begin
				if (out_free && hst_q == H_DONE) begin
					upd     = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_MISS: begin
				if (out_free) begin
					miss_emit = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// ---- heading sequencer ----
	always_comb begin
		hst_d  = hst_q;
		hcnt_d = hcnt_q;
		mh_ctl = '0;
		unique case (hst_q)
			H_IDLE: begin
				if (h_start) begin
					mh_ctl.load = 1'b1;
					hcnt_d      = '0;
					hst_d       = H_MUL1;
				end
			end
			H_MUL1: begin
				mh_ctl.step = 1'b1;
				if (hcnt_q == ITER_W'(SHORT_STEPS - 1)) begin
					hst_d = H_LOAD2;
				end else begin
					hcnt_d = hcnt_q + 1'b1;
				end
			end
			H_LOAD2: begin
				mh_ctl.load = 1'b1;
				hcnt_d      = '0;
				hst_d       = H_MUL2;
			end
			H_MUL2: begin
				mh_ctl.step = 1'b1;
				if (hcnt_q == ITER_W'(LONG_STEPS - 1)) begin
					hst_d = H_DONE;
				end else begin
					hcnt_d = hcnt_q + 1'b1;
				end
			end
			H_DONE: begin
				if (upd) begin
					hst_d = H_IDLE;
				end
			end
			default: hst_d = H_IDLE;
		endcase
	end

	// ---- state registers ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			hst_q    <= H_IDLE;
			cnt_q    <= '0;
			hcnt_q   <= '0;
			px_q     <= '0;
			py_q     <= '0;
			hd_q     <= '0;
			missed_q <= '0;
			bad_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			hst_q   <= hst_d;
			cnt_q   <= cnt_d;
			hcnt_q  <= hcnt_d;
			if (upd) begin
				px_q <= px_new;
				py_q <= py_new;
				hd_q <= hd_new;
			end
			if (miss_emit) begin
				missed_q <= missed_inc;
			end
			if (bad_hit) begin
				bad_q <= bad_inc;
			end
			if (upd || miss_emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// sample capture
	always_ff @(posedge clk) begin
		if (cap_en) begin
			vx_q  <= vel_x;
			vy_q  <= vel_y;
			vt_q  <= turn_rate;
			per_q <= period;
		end
	end

	// output payload: low 32 bits of position, low 16 bits of angle
	always_comb begin
		if (upd) begin
			px_ext = {{32{px_new[POSITION_BITS-1]}}, px_new};
			py_ext = {{32{py_new[POSITION_BITS-1]}}, py_new};
			hd_ext = {16'b0, hd_new};
		end else begin
			px_ext = {{32{px_q[POSITION_BITS-1]}}, px_q};
			py_ext = {{32{py_q[POSITION_BITS-1]}}, py_q};
			hd_ext = {16'b0, hd_q};
		end
	end

	always_ff @(posedge clk) begin
		if (upd || miss_emit) begin
			pos_x_q    <= px_ext[31:0];
			pos_y_q    <= py_ext[31:0];
			heading_q  <= hd_ext[15:0];
			ovx_q      <= upd ? vx_q : 16'sd0;
			ovy_q      <= upd ? vy_q : 16'sd0;
			ovt_q      <= upd ? vt_q : 16'sd0;
			missed_o_q <= miss_emit ? missed_inc : missed_q;
			bad_o_q    <= bad_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign pos_x         = pos_x_q;
	assign pos_y         = pos_y_q;
	assign heading       = heading_q;
	assign out_vel_x     = ovx_q;
	assign out_vel_y     = ovy_q;
	assign out_turn_rate = ovt_q;
	assign missed_reads  = missed_o_q;
	assign bad_samples   = bad_o_q;

endmodule
